// ----- hw/rtl/kpf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kpf_pkg;

    localparam int unsigned KeyWidth   = 8;
    localparam int unsigned CountWidth = 4;
    localparam int unsigned ScanWidth  = 32;

    localparam logic [CountWidth-1:0] REQUIRED_READS_RESET = 4'd3;
    localparam logic [KeyWidth-1:0]   ALLOWED_KEYS_RESET   = 8'hFD;

    typedef enum logic [1:0] {
        CFG_REQUIRED_READS = 2'd0,
        CFG_ALLOWED_KEYS   = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic [CountWidth-1:0] required_reads;
        logic [KeyWidth-1:0]   allowed_single_keys;
    } t_kpf_cfg;

    typedef struct packed {
        logic [KeyWidth-1:0] accepted_keys;
        logic [KeyWidth-1:0] new_press;
    } t_kpf_result;

    // bits 0 and 4 of each byte, byte a lands highest in each nibble
    function automatic logic [KeyWidth-1:0] pack_mask(input logic [ScanWidth-1:0] scan);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        a = scan[7:0];
        b = scan[15:8];
        c = scan[23:16];
        d = scan[31:24];
        return {a[4], b[4], c[4], d[4], a[0], b[0], c[0], d[0]};
    endfunction

    // all released, or a single allowed key
    function automatic logic mask_valid(input logic [KeyWidth-1:0] m,
                                        input logic [KeyWidth-1:0] allowed);
        logic [KeyWidth-1:0] m_dec;
        m_dec = m - KeyWidth'(1);
        if (m == '0) begin
            return 1'b1;
        end
        return ((m & m_dec) == '0) && ((m & allowed) != '0);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kpf_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kpf_core
    import kpf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [ScanWidth-1:0] i_scan,
    input  wire t_kpf_cfg             i_cfg,
    output t_kpf_result               o_result
);

    logic [KeyWidth-1:0]   r_candidate;
    logic [CountWidth-1:0] r_count;
    logic [KeyWidth-1:0]   r_trusted;

    logic [KeyWidth-1:0]   n_candidate;
    logic [CountWidth-1:0] n_count;
    logic [KeyWidth-1:0]   n_trusted;

    logic [KeyWidth-1:0]   mask;
    logic                  valid;
    logic                  take;

    always_comb begin
        mask        = pack_mask(i_scan);
        valid       = mask_valid(mask, i_cfg.allowed_single_keys);
        n_candidate = r_candidate;
        n_count     = r_count;
        n_trusted   = r_trusted;
        o_result    = '{accepted_keys: r_trusted, new_press: '0};
        take        = 1'b0;
        if (valid) begin
            if (mask != r_candidate) begin
                n_candidate = mask;
                n_count     = CountWidth'(1);
            end else if (r_count < i_cfg.required_reads) begin
                n_count = r_count + CountWidth'(1);
            end
            take = (n_count >= i_cfg.required_reads) && (mask != r_trusted);
            if (take) begin
                n_trusted = mask;
                o_result.accepted_keys = mask;
                // a press only counts when coming from all released
                if (r_trusted == '0) begin
                    o_result.new_press = mask;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_candidate <= '0;
            r_count     <= '0;
            r_trusted   <= '0;
        end else if (i_fire) begin
            r_candidate <= n_candidate;
            r_count     <= n_count;
            r_trusted   <= n_trusted;
        end
    end

    a_invalid_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !valid) |=>
            ($stable(r_candidate) && $stable(r_count) && $stable(r_trusted)))
        else $error("invalid scan changed debounce state");

    a_trusted_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_trusted))
        else $error("trusted keys changed without a scan");

    a_press_from_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.new_press != '0) |-> (r_trusted == '0))
        else $error("press reported while a key was already held");

    a_trusted_single_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_trusted != '0) |-> $onehot(r_trusted))
        else $error("trusted keys hold more than one key");

    a_candidate_single_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_candidate != '0) |-> $onehot(r_candidate))
        else $error("candidate keys hold more than one key");

endmodule

`default_nettype wire

// ----- hw/rtl/panel_key_press_filter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Key press filter: each scan request on s_axis (four raw key bytes) yields exactly one
// result on m_axis carrying the new press mask and the debounced key mask. One scan can
// be taken every clock while m_axis is not stalled; a taken scan is held in the input
// register, which feeds the debounce compare-and-count update straight into the result
// register. The debounce state update is what sets this rate. The config channel is
// always ready: index 0 sets required_reads (low 4 data bits), index 1 sets
// allowed_single_keys; other indexes are ignored. Write config only while idle.
module panel_key_press_filter_unit
    import kpf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // key_byte_a [7:0], key_byte_b [15:8], key_byte_c [23:16], key_byte_d [31:24]
    input  wire logic [ScanWidth-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // new_press [7:0], accepted_keys [15:8]
    output logic [2*KeyWidth-1:0]       m_axis_tdata,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [KeyWidth-1:0]    i_cfg_data
);

    logic                 r_in_valid;
    logic [ScanWidth-1:0] r_in_scan;
    logic                 r_out_valid;
    t_kpf_result          r_out_result;
    t_kpf_cfg             r_cfg;

    logic                 advance;
    t_kpf_result          result;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_result.accepted_keys, r_out_result.new_press};

    kpf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_scan   (r_in_scan),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= '{required_reads: REQUIRED_READS_RESET,
                             allowed_single_keys: ALLOWED_KEYS_RESET};
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_REQUIRED_READS) begin
                    r_cfg.required_reads <= i_cfg_data[CountWidth-1:0];
                end else if (i_cfg_index == CFG_ALLOWED_KEYS) begin
                    r_cfg.allowed_single_keys <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_scan <= s_axis_tdata;
        end
        if (advance) begin
            r_out_result <= result;
        end
    end

endmodule

`default_nettype wire
